// ===== rtl/ppe_pkg.sv =====
package ppe_pkg;

  // Field widths.
  localparam int COORD_BITS_DEF = 32;
  localparam int IN_W           = 32;
  localparam int BOX_W          = 32;
  localparam int R2_W           = 64;
  localparam int COEF_W         = 48;
  localparam int E_W            = 48;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 64;

  // Widths of the powers of r2 and of the energy fraction.
  localparam int R2P_W = 2 * R2_W;
  localparam int R3_W  = 3 * R2_W;
  localparam int R6_W  = 6 * R2_W;
  localparam int BR3_W = COEF_W + R3_W;
  localparam int MAG_W = R6_W;

  // Alignment shifts of the two energy terms.
  localparam int SH_REP = 288;
  localparam int SH_ATT = 144;

  // Multiplier adder tree depth and latency, divider steps.
  localparam int MUL_LVL   = 6;
  localparam int MUL_LAT   = MUL_LVL + 1;
  localparam int DIV_STEPS = E_W + 1;

  // Register reset values.
  localparam logic [BOX_W-1:0]  BOX_RST    = '1;
  localparam logic [R2_W-1:0]   CUTOFF_RST = 64'hC000_0000_0000_0000;
  localparam logic [COEF_W-1:0] COEF_RST   = 48'h0000_0100_0000;

  // Energy limits.
  localparam logic [E_W-1:0] E_POS_LIM = {1'b0, {(E_W-1){1'b1}}};
  localparam logic [E_W-1:0] E_NEG_LIM = {1'b1, {(E_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX    = 4'd0,
    REG_CUTOFF = 4'd1,
    REG_REP    = 4'd2,
    REG_ATT    = 4'd3
  } cfg_reg_t;

endpackage

// ===== rtl/ppe_dly.sv =====
module ppe_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [N];

  // Plain shift line, one register per cycle of delay.
  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int s = 1; s < N; s++) begin
      tap_r[s] <= tap_r[s-1];
    end
  end

  assign dout = tap_r[N-1];

endmodule

// ===== rtl/ppe_mod.sv =====
module ppe_mod #(
  parameter int CB = 32
) (
  input  logic          clk,
  input  logic [CB-1:0] din,
  input  logic [CB:0]   edge_len,
  output logic [CB-1:0] rem
);

  localparam int W2 = 2 * CB + 1;

  logic [CB-1:0] stg_in  [CB];
  logic [CB-1:0] rem_nxt [CB];
  logic [CB-1:0] rem_r   [CB];

  // Stage inputs: the first stage takes the difference, the rest the stage before.
  always_comb begin
    stg_in[0] = din;
    for (int s = 1; s < CB; s++) begin
      stg_in[s] = rem_r[s-1];
    end
  end

  // Restoring remainder, one bit of the quotient per stage from the top.
  always_comb begin
    logic [W2-1:0] sh;
    for (int s = 0; s < CB; s++) begin
      sh = W2'(edge_len) << (CB - 1 - s);
      if (W2'(stg_in[s]) >= sh) begin
        rem_nxt[s] = CB'(W2'(stg_in[s]) - sh);
      end else begin
        rem_nxt[s] = stg_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < CB; s++) begin
      rem_r[s] <= rem_nxt[s];
    end
  end

  assign rem = rem_r[CB-1];

endmodule

// ===== rtl/ppe_mul.sv =====
module ppe_mul #(
  parameter int WA  = 64,
  parameter int WB  = 64,
  parameter int LVL = 6
) (
  input  logic               clk,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   p
);

  localparam int WP = WA + WB;
  localparam int LA = (WA + 31) / 32;
  localparam int LB = (WB + 31) / 32;
  localparam int P2 = 1 << LVL;

  logic [LA*32-1:0] a_pad;
  logic [LB*32-1:0] b_pad;
  logic [WP-1:0]    pp    [P2];
  logic [WP-1:0]    lv_r  [LVL+1][P2];

  assign a_pad = (LA*32)'(a);
  assign b_pad = (LB*32)'(b);

  // Partial products of 32-bit limbs, each placed at its column.
  always_comb begin
    logic [63:0] prod;
    for (int e = 0; e < P2; e++) begin
      pp[e] = '0;
    end
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        prod = a_pad[32*i +: 32] * b_pad[32*j +: 32];
        pp[i*LB+j] = WP'(prod) << (32 * (i + j));
      end
    end
  end

  // Registered products, then a registered pairwise adder tree.
  always_ff @(posedge clk) begin
    for (int e = 0; e < P2; e++) begin
      lv_r[0][e] <= pp[e];
    end
    for (int l = 1; l <= LVL; l++) begin
      for (int e = 0; e < P2; e++) begin
        if (e < (P2 >> l)) begin
          lv_r[l][e] <= lv_r[l-1][2*e] + lv_r[l-1][2*e+1];
        end else begin
          lv_r[l][e] <= '0;
        end
      end
    end
  end

  assign p = lv_r[LVL][0];

endmodule

// ===== rtl/ppe_div.sv =====
module ppe_div #(
  parameter int DW = 384,
  parameter int QB = 49
) (
  input  logic          clk,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int CW = DW + QB - 1;

  logic [DW-1:0] rem_in  [QB];
  logic [DW-1:0] den_in  [QB];
  logic [QB-1:0] quo_in  [QB];
  logic [DW-1:0] rem_nxt [QB];
  logic          bit_nxt [QB];
  logic [DW-1:0] rem_r   [QB];
  logic [DW-1:0] den_r   [QB];
  logic [QB-1:0] quo_r   [QB];

  // Stage inputs.
  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int s = 1; s < QB; s++) begin
      rem_in[s] = rem_r[s-1];
      den_in[s] = den_r[s-1];
      quo_in[s] = quo_r[s-1];
    end
  end

  // One quotient bit per stage, most significant first.
  always_comb begin
    logic [CW-1:0] sh;
    for (int s = 0; s < QB; s++) begin
      sh = CW'(den_in[s]) << (QB - 1 - s);
      bit_nxt[s] = (CW'(rem_in[s]) >= sh);
      if (bit_nxt[s]) begin
        rem_nxt[s] = DW'(CW'(rem_in[s]) - sh);
      end else begin
        rem_nxt[s] = rem_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QB; s++) begin
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_in[s];
      quo_r[s] <= {quo_in[s][QB-2:0], bit_nxt[s]};
    end
  end

  assign quo = quo_r[QB-1];

endmodule

// ===== rtl/periodic_pair_energy.sv =====
// Throughput: one item per cycle; busy is high only during reset and in the cycle after it.
// The depth comes from the bit-per-stage remainder and divider pipelines and the
// limb-split multipliers. Results cannot be stalled by the receiver.
// Reset (synchronous, rst_n low) clears the item pipeline and restores the registers.
module periodic_pair_energy import ppe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [IN_W-1:0]        in_first_x,
  input  logic [IN_W-1:0]        in_first_y,
  input  logic [IN_W-1:0]        in_first_z,
  input  logic [IN_W-1:0]        in_second_x,
  input  logic [IN_W-1:0]        in_second_y,
  input  logic [IN_W-1:0]        in_second_z,
  output logic                   out_strobe,
  output logic [R2_W-1:0]        out_dist_sq,
  output logic signed [E_W-1:0]  out_pair_energy,
  output logic                   out_within_cutoff,
  output logic                   out_saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int SIDE = 3 * MUL_LAT + 1 + DIV_STEPS;
  localparam int LAT  = CB + 6 + 3 * MUL_LAT + DIV_STEPS;

  logic                busy_r;
  logic [LAT-1:0]      vld_r;
  logic                accept;

  logic [BOX_W-1:0]    box_r;
  logic [R2_W-1:0]     cutoff_r;
  logic [COEF_W-1:0]   coef_rep_r;
  logic [COEF_W-1:0]   coef_att_r;

  logic [CB-1:0]       box_low;
  logic [CB:0]         edge_len;
  logic [CB-1:0]       pa [3];
  logic [CB-1:0]       pb [3];
  logic [CB-1:0]       diff_r [3];
  logic [CB-1:0]       mod_q [3];
  logic [CB:0]         far_img [3];
  logic [CB-1:0]       img_r [3];
  logic [2*CB-1:0]     sq_r [3];
  logic [R2_W-1:0]     r2_r;

  logic [R2P_W-1:0]    r2p;
  logic [R2_W-1:0]     r_dl;
  logic [R3_W-1:0]     r3;
  logic [R6_W-1:0]     r6;
  logic [BR3_W-1:0]    br3;
  logic [MAG_W-1:0]    n_rep;
  logic [MAG_W-1:0]    n_att;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [R6_W-1:0]     r6_r;
  logic                neg_dl;
  logic [DIV_STEPS-1:0] quo;
  logic [R2_W-1:0]     r2_fin;

  logic                in_cut;
  logic                sat_nxt;
  logic [E_W-1:0]      energy_nxt;
  logic [R2_W-1:0]     dist_r;
  logic [E_W-1:0]      energy_r;
  logic                within_r;
  logic                sat_r;

  // Handshake and item valid pipeline.
  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LAT-2:0], accept};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r      <= BOX_RST;
      cutoff_r   <= CUTOFF_RST;
      coef_rep_r <= COEF_RST;
      coef_att_r <= COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX:    box_r      <= cfg_data[BOX_W-1:0];
        REG_CUTOFF: cutoff_r   <= cfg_data[R2_W-1:0];
        REG_REP:    coef_rep_r <= cfg_data[COEF_W-1:0];
        REG_ATT:    coef_att_r <= cfg_data[COEF_W-1:0];
        default:    ;
      endcase
    end
  end

  // A zero box edge means a full modular wrap of the coordinate width.
  assign box_low  = box_r[CB-1:0];
  assign edge_len = (box_low == '0) ? {1'b1, {CB{1'b0}}} : {1'b0, box_low};

  // Absolute per-axis difference.
  assign pa[0] = in_first_x[CB-1:0];
  assign pa[1] = in_first_y[CB-1:0];
  assign pa[2] = in_first_z[CB-1:0];
  assign pb[0] = in_second_x[CB-1:0];
  assign pb[1] = in_second_y[CB-1:0];
  assign pb[2] = in_second_z[CB-1:0];

  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 3; ax++) begin
      diff_r[ax] <= (pa[ax] > pb[ax]) ? pa[ax] - pb[ax] : pb[ax] - pa[ax];
    end
  end

  // Difference reduced modulo the box edge.
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    ppe_mod #(.CB(CB)) u_mod (
      .clk      (clk),
      .din      (diff_r[ax]),
      .edge_len (edge_len),
      .rem      (mod_q[ax])
    );
  end

  // Minimum image, its square, and the squared distance.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      far_img[ax] = edge_len - {1'b0, mod_q[ax]};
    end
  end

  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 3; ax++) begin
      img_r[ax] <= ({1'b0, mod_q[ax]} < far_img[ax]) ? mod_q[ax] : far_img[ax][CB-1:0];
      sq_r[ax]  <= img_r[ax] * img_r[ax];
    end
    r2_r <= R2_W'(sq_r[0]) + R2_W'(sq_r[1]) + R2_W'(sq_r[2]);
  end

  // Powers of r2 and the attractive numerator term.
  ppe_mul #(.WA(R2_W), .WB(R2_W), .LVL(MUL_LVL)) u_mul_r2 (
    .clk (clk), .a (r2_r), .b (r2_r), .p (r2p)
  );

  ppe_dly #(.W(R2_W), .N(MUL_LAT)) u_dly_r (
    .clk (clk), .din (r2_r), .dout (r_dl)
  );

  ppe_mul #(.WA(R2P_W), .WB(R2_W), .LVL(MUL_LVL)) u_mul_r3 (
    .clk (clk), .a (r2p), .b (r_dl), .p (r3)
  );

  ppe_mul #(.WA(R3_W), .WB(R3_W), .LVL(MUL_LVL)) u_mul_r6 (
    .clk (clk), .a (r3), .b (r3), .p (r6)
  );

  ppe_mul #(.WA(COEF_W), .WB(R3_W), .LVL(MUL_LVL)) u_mul_br3 (
    .clk (clk), .a (coef_att_r), .b (r3), .p (br3)
  );

  // Numerator magnitude and sign of A*2^288 - B*R^3*2^144.
  assign n_rep = MAG_W'(coef_rep_r) << SH_REP;
  assign n_att = MAG_W'(br3) << SH_ATT;

  always_ff @(posedge clk) begin
    neg_r <= (n_rep < n_att);
    mag_r <= (n_rep < n_att) ? n_att - n_rep : n_rep - n_att;
    r6_r  <= r6;
  end

  ppe_div #(.DW(MAG_W), .QB(DIV_STEPS)) u_div (
    .clk (clk), .num (mag_r), .den (r6_r), .quo (quo)
  );

  ppe_dly #(.W(1), .N(DIV_STEPS)) u_dly_neg (
    .clk (clk), .din (neg_r), .dout (neg_dl)
  );

  ppe_dly #(.W(R2_W), .N(SIDE)) u_dly_r2 (
    .clk (clk), .din (r2_r), .dout (r2_fin)
  );

  // Cutoff test, special cases and saturation.
  assign in_cut = (r2_fin <= cutoff_r);

  always_comb begin
    sat_nxt    = 1'b0;
    energy_nxt = '0;
    if (in_cut && (r2_fin == '0)) begin
      sat_nxt = 1'b1;
      if (coef_rep_r != '0) begin
        energy_nxt = E_POS_LIM;
      end else if (coef_att_r != '0) begin
        energy_nxt = E_NEG_LIM;
      end
    end else if (in_cut) begin
      if (!neg_dl) begin
        if (quo > DIV_STEPS'(E_POS_LIM)) begin
          energy_nxt = E_POS_LIM;
          sat_nxt    = 1'b1;
        end else begin
          energy_nxt = quo[E_W-1:0];
        end
      end else begin
        if (quo > DIV_STEPS'(E_NEG_LIM)) begin
          energy_nxt = E_NEG_LIM;
          sat_nxt    = 1'b1;
        end else begin
          energy_nxt = E_W'(0) - quo[E_W-1:0];
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    dist_r   <= r2_fin;
    energy_r <= energy_nxt;
    within_r <= in_cut;
    sat_r    <= sat_nxt;
  end

  assign out_strobe        = vld_r[LAT-1];
  assign out_dist_sq       = dist_r;
  assign out_pair_energy   = energy_r;
  assign out_within_cutoff = within_r;
  assign out_saturated     = sat_r;

endmodule

// ===== rtl/ppe_chk.sv =====
module ppe_chk import ppe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_strobe,
  input logic [R2_W-1:0]       out_dist_sq,
  input logic signed [E_W-1:0] out_pair_energy,
  input logic                  out_within_cutoff,
  input logic                  out_saturated
);

  // Beyond the cutoff the energy is zero and nothing is clipped.
  a_far_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_within_cutoff |-> out_pair_energy == '0 && !out_saturated)
    else $error("energy or flag set beyond cutoff");

  // A coincident pair inside the cutoff is always flagged.
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_within_cutoff && out_dist_sq == '0 |-> out_saturated)
    else $error("zero distance not flagged");

  // A flagged non-negative energy sits on the positive limit or is zero.
  a_pos_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_saturated && !out_pair_energy[E_W-1]
      |-> out_pair_energy == E_POS_LIM || out_pair_energy == '0)
    else $error("positive clip value wrong");

  // A flagged negative energy sits on the negative limit.
  a_neg_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_saturated && out_pair_energy[E_W-1]
      |-> out_pair_energy == E_NEG_LIM)
    else $error("negative clip value wrong");

endmodule

bind periodic_pair_energy ppe_chk u_ppe_chk (.*);

// ===== dv/periodic_pair_energy_tb.sv =====
module periodic_pair_energy_tb import ppe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth at 32-bit coordinates, plus some margin.
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int NUM_PHASES = 7;
  localparam int RAND_PER_PHASE = 135;

  typedef struct packed {
    logic [IN_W-1:0] ax, ay, az, bx, by, bz;
  } pair_item_t;

  typedef struct packed {
    logic [R2_W-1:0] dist_sq;
    logic [E_W-1:0]  energy;
    logic            in_cut;
    logic            sat;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IN_W-1:0] in_first_x = '0, in_first_y = '0, in_first_z = '0;
  logic [IN_W-1:0] in_second_x = '0, in_second_y = '0, in_second_z = '0;
  logic out_strobe;
  logic [R2_W-1:0] out_dist_sq;
  logic signed [E_W-1:0] out_pair_energy;
  logic out_within_cutoff, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  periodic_pair_energy u_top (.*);

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [BOX_W-1:0]  box_len  = BOX_RST;
  logic [R2_W-1:0]   cut_sq   = CUTOFF_RST;
  logic [COEF_W-1:0] coef_rep = COEF_RST;
  logic [COEF_W-1:0] coef_att = COEF_RST;

  pair_item_t   pending_pairs[$];
  pair_result_t expected_energies[$];
  int idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  // Minimum-image distance along one axis.
  function automatic logic [63:0] axis_gap(logic [31:0] a, logic [31:0] b);
    logic [63:0] edge_len, d, m, e;
    edge_len = (box_len == '0) ? 64'h1_0000_0000 : {32'd0, box_len};
    d = (a > b) ? {32'd0, a - b} : {32'd0, b - a};
    m = d % edge_len;
    e = edge_len - m;
    return (m < e) ? m : e;
  endfunction

  // Squared distance and exact Lennard-Jones energy with saturation.
  function automatic pair_result_t pair_energy_of(pair_item_t it);
    pair_result_t res;
    logic [63:0] dx, dy, dz;
    logic [511:0] rr, r3, r6, n1, n2, mag, q;
    logic neg;
    dx = axis_gap(it.ax, it.bx);
    dy = axis_gap(it.ay, it.by);
    dz = axis_gap(it.az, it.bz);
    res.dist_sq = dx * dx + dy * dy + dz * dz;
    res.in_cut = (res.dist_sq <= cut_sq);
    res.energy = '0;
    res.sat = 1'b0;
    if (res.in_cut && res.dist_sq == '0) begin
      // Coincident particles: clip to the positive limit if the repulsive term exists, else toward the attractive one.
      res.sat = 1'b1;
      if (coef_rep != '0) res.energy = E_POS_LIM;
      else if (coef_att != '0) res.energy = E_NEG_LIM;
    end else if (res.in_cut) begin
      rr = 512'(res.dist_sq);
      r3 = rr * rr * rr;
      r6 = r3 * r3;
      n1 = 512'(coef_rep) << SH_REP;
      n2 = (512'(coef_att) * r3) << SH_ATT;
      neg = (n1 < n2);
      mag = neg ? n2 - n1 : n1 - n2;
      q = mag / r6;
      if (!neg) begin
        if (q > 512'(E_POS_LIM)) begin
          res.energy = E_POS_LIM;
          res.sat = 1'b1;
        end else begin
          res.energy = q[E_W-1:0];
        end
      end else begin
        if (q > 512'(E_NEG_LIM)) begin
          res.energy = E_NEG_LIM;
          res.sat = 1'b1;
        end else begin
          res.energy = E_W'(0) - q[E_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // Driver: presents queued items, accepted when start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_energies.push_back(pair_energy_of(pending_pairs[0]));
        pending_pairs.pop_front();
      end
      if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_first_x  <= pending_pairs[0].ax;
        in_first_y  <= pending_pairs[0].ay;
        in_first_z  <= pending_pairs[0].az;
        in_second_x <= pending_pairs[0].bx;
        in_second_y <= pending_pairs[0].by;
        in_second_z <= pending_pairs[0].bz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    pair_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_energies.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        exp_r = expected_energies.pop_front();
        if (out_dist_sq !== exp_r.dist_sq) begin
          $error("dist_sq expected %h actual %h", exp_r.dist_sq, out_dist_sq);
          errors++;
        end
        if (out_pair_energy !== exp_r.energy) begin
          $error("pair_energy expected %h actual %h", exp_r.energy, out_pair_energy);
          errors++;
        end
        if (out_within_cutoff !== exp_r.in_cut) begin
          $error("within_cutoff expected %b actual %b", exp_r.in_cut, out_within_cutoff);
          errors++;
        end
        if (out_saturated !== exp_r.sat) begin
          $error("saturated expected %b actual %b", exp_r.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("periodic_pair_energy regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_BOX:    box_len  = val[BOX_W-1:0];
      REG_CUTOFF: cut_sq   = val[R2_W-1:0];
      REG_REP:    coef_rep = val[COEF_W-1:0];
      REG_ATT:    coef_att = val[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_pair(logic [31:0] ax, ay, az, bx, by, bz);
    pair_item_t it;
    it = '{ax, ay, az, bx, by, bz};
    pending_pairs.push_back(it);
  endtask

  // Random coordinate, mostly inside the box.
  function automatic logic [31:0] rand_coord();
    if (box_len == '0 || $urandom_range(9) == 0) return $urandom;
    return $urandom_range(box_len - 1, 0);
  endfunction

  // Small signed offset so that energies land in the interesting range.
  function automatic logic [31:0] rand_offset();
    logic [31:0] d;
    d = $urandom_range(0, (1 << $urandom_range(27, 0)));
    return $urandom_range(1) ? d : -d;
  endfunction

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || expected_energies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ax, ay, az;
    int kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at reset configuration.
    push_pair(0, 0, 0, 0, 0, 0);
    push_pair('1, '1, '1, '1, '1, '1);
    push_pair(0, 0, 0, '1, '1, '1);
    push_pair('1, 0, '1, 0, '1, 0);
    push_pair(32'h0100_0000, 0, 0, 0, 0, 0);
    push_pair(32'h0120_0000, 32'h0080_0000, 0, 0, 0, 0);
    push_pair(1, 0, 0, 0, 0, 0);
    push_pair(32'h0800_0000, 32'h0800_0000, 32'h0800_0000, 0, 0, 0);
    push_pair(32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_pair(32'h0300_0000, 32'h0200_0000, 32'h0100_0000, 0, 0, 0);
    wait_idle();

    // Zero distance with only the attractive term, then zero and nonzero distance with neither term.
    write_reg(REG_REP, 0);
    push_pair(5, 6, 7, 5, 6, 7);
    wait_idle();
    write_reg(REG_ATT, 0);
    push_pair(5, 6, 7, 5, 6, 7);
    push_pair(32'h0100_0000, 0, 0, 0, 0, 0);
    wait_idle();
    // Unknown index must leave the registers alone.
    write_reg(REG_UNUSED, 64'h1234);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_BOX, 0);
          write_reg(REG_CUTOFF, '1);
          write_reg(REG_REP, 64'h100_0000);
          write_reg(REG_ATT, 64'h100_0000);
        end
        1: begin
          write_reg(REG_BOX, 64'h0A00_0000);
          write_reg(REG_CUTOFF, 64'h9 << 48);
          write_reg(REG_ATT, 64'h200_0000);
        end
        2: begin
          write_reg(REG_BOX, 1);
          write_reg(REG_CUTOFF, 0);
          write_reg(REG_REP, '1);
          write_reg(REG_ATT, '1);
        end
        3: begin
          write_reg(REG_BOX, 64'hFFFF_FFFF);
          write_reg(REG_CUTOFF, 64'h4 << 48);
          write_reg(REG_REP, 0);
          write_reg(REG_ATT, {$urandom, $urandom});
        end
        4: begin
          write_reg(REG_BOX, 64'h0400_0000 + $urandom_range(32'h3FFF_FFFF));
          write_reg(REG_CUTOFF, {$urandom_range(63), $urandom});
          write_reg(REG_REP, {$urandom, $urandom});
          write_reg(REG_ATT, $urandom_range(32'h0FFF_FFFF));
        end
        5: begin
          write_reg(REG_BOX, $urandom);
          write_reg(REG_CUTOFF, {$urandom, $urandom});
          write_reg(REG_REP, 64'h40_0000 + $urandom_range(32'h0400_0000));
          write_reg(REG_ATT, 64'h40_0000 + $urandom_range(32'h0400_0000));
        end
        default: begin
          write_reg(REG_BOX, 64'h2000_0000);
          write_reg(REG_CUTOFF, 64'h10 << 48);
          write_reg(REG_REP, 64'h100_0000);
          write_reg(REG_ATT, 64'h100_0000);
        end
      endcase
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 60 : 19);

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        kind = $urandom_range(99);
        ax = rand_coord();
        ay = rand_coord();
        az = rand_coord();
        if (kind < 5) begin
          push_pair(ax, ay, az, ax, ay, az);
        end else if (kind < 25) begin
          push_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (kind < 40) begin
          push_pair(ax, ay, az, rand_coord(), rand_coord(), rand_coord());
        end else begin
          push_pair(ax, ay, az, ax + rand_offset(), ay + rand_offset(), az + rand_offset());
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("periodic_pair_energy regression: pass");
    end else begin
      $display("periodic_pair_energy regression: fail");
    end
    $finish;
  end

endmodule
